### rtl/pwm_channel_with_clock_divider_assert.svh
// Assertion macros shared by the checker of the pwm channel.
`ifndef PWM_CHANNEL_WITH_CLOCK_DIVIDER_ASSERT_SVH
`define PWM_CHANNEL_WITH_CLOCK_DIVIDER_ASSERT_SVH

// same-cycle implication, masked during reset
`define PWMCD_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, masked during reset
`define PWMCD_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// next-cycle implication, checked through reset
`define PWMCD_ASSERT_RST(label, ante, cons, msg) \
   label: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/pwmcd_pkg.sv
// Package: types and constants of the pwm channel with clock divider.
package pwmcd_pkg;

   localparam int DIVISOR_BITS = 12;
   localparam int DATA_BITS    = 32;
   localparam int INDEX_BITS   = 6;
   localparam int DIV_SHIFT    = 12;
   localparam int CLK_CTL_BITS = 6;
   localparam int PWM_CTL_BITS = 8;

   localparam logic [7:0] CLK_PASSWORD = 8'h5A;

   localparam logic [INDEX_BITS-1:0] CLK_CTL_WORD = 6'd40;
   localparam logic [INDEX_BITS-1:0] CLK_DIV_WORD = 6'd41;
   localparam logic [INDEX_BITS-1:0] PWM_CTL_WORD = 6'd0;
   localparam logic [INDEX_BITS-1:0] PWM_RNG_WORD = 6'd4;
   localparam logic [INDEX_BITS-1:0] PWM_DAT_WORD = 6'd5;

   localparam logic BLK_CLOCK = 1'b0;

   localparam int CLK_EN_BIT   = 4;
   localparam int CLK_KILL_BIT = 5;
   localparam int PWM_EN_BIT   = 0;
   localparam int PWM_MS_BIT   = 7;

   typedef enum logic [1:0] {
      FUNC_TICK  = 2'd0,
      FUNC_WRITE = 2'd1,
      FUNC_READ  = 2'd2,
      FUNC_NONE  = 2'd3
   } func_type;

   typedef struct packed {
      func_type                func;
      logic                    block_sel;
      logic [INDEX_BITS-1:0]   word_index;
      logic [DATA_BITS-1:0]    write_value;
   } item_type;

   typedef struct packed {
      logic [DATA_BITS-1:0] read_value;
      logic                 pwm_level;
   } result_type;

endpackage

### rtl/pwmcd_in_stage.sv
// Input register: holds one accepted request beat until the core consumes it.
module pwmcd_in_stage (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [1:0]                        req_func,
   input  logic                              req_block_sel,
   input  logic [pwmcd_pkg::INDEX_BITS-1:0]  req_word_index,
   input  logic [pwmcd_pkg::DATA_BITS-1:0]   req_write_value,
   input  logic                              advance,
   output logic                              item_valid,
   output pwmcd_pkg::item_type               item
);
   import pwmcd_pkg::*;

   logic     valid_ff;
   logic     valid_in;
   item_type item_ff;
   logic     take;

   assign req_ready = !valid_ff || advance;
   assign take      = req_valid && req_ready;
   assign valid_in  = take ? 1'b1 : (advance ? 1'b0 : valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         item_ff.func        <= func_type'(req_func);
         item_ff.block_sel   <= req_block_sel;
         item_ff.word_index  <= req_word_index;
         item_ff.write_value <= req_write_value;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

### rtl/pwmcd_core.sv
// Core: clock manager and pwm registers, prescaler, period counter and read mux.
module pwmcd_core (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   fire,
   input  pwmcd_pkg::item_type    item,
   output pwmcd_pkg::result_type  result
);
   import pwmcd_pkg::*;

   logic [CLK_CTL_BITS-1:0] clk_ctl_ff, clk_ctl_in;
   logic [DIVISOR_BITS-1:0] clk_div_ff, clk_div_in;
   logic [DIVISOR_BITS-1:0] pre_ff,     pre_in;
   logic [PWM_CTL_BITS-1:0] pwm_ctl_ff, pwm_ctl_in;
   logic [DATA_BITS-1:0]    range_ff,   range_in;
   logic [DATA_BITS-1:0]    duty_ff,    duty_in;
   logic [DATA_BITS-1:0]    count_ff,   count_in;

   logic                    running;
   logic [DIVISOR_BITS-1:0] div_eff;
   logic [DIVISOR_BITS:0]   pre_inc;
   logic [DATA_BITS:0]      count_inc;
   logic                    password_ok;
   logic [DATA_BITS-1:0]    rd_value;

   assign running     = clk_ctl_ff[CLK_EN_BIT] && !clk_ctl_ff[CLK_KILL_BIT];
   assign div_eff     = (clk_div_ff == '0) ? DIVISOR_BITS'(1) : clk_div_ff;
   assign pre_inc     = {1'b0, pre_ff} + (DIVISOR_BITS + 1)'(1);
   assign count_inc   = {1'b0, count_ff} + (DATA_BITS + 1)'(1);
   assign password_ok = (item.write_value[DATA_BITS-1 -: 8] == CLK_PASSWORD);

   always_comb begin
      clk_ctl_in = clk_ctl_ff;
      clk_div_in = clk_div_ff;
      pre_in     = pre_ff;
      pwm_ctl_in = pwm_ctl_ff;
      range_in   = range_ff;
      duty_in    = duty_ff;
      count_in   = count_ff;
      rd_value   = '0;
      if (fire) begin
         case (item.func)
            FUNC_TICK: begin
               if (running) begin
                  if (pre_inc >= {1'b0, div_eff}) begin
                     pre_in = '0;
                     if (!pwm_ctl_ff[PWM_EN_BIT] || range_ff == '0) begin
                        count_in = '0;
                     end else if (count_inc >= {1'b0, range_ff}) begin
                        count_in = '0;
                     end else begin
                        count_in = count_inc[DATA_BITS-1:0];
                     end
                  end else begin
                     pre_in = pre_inc[DIVISOR_BITS-1:0];
                  end
               end
            end
            FUNC_WRITE: begin
               if (item.block_sel == BLK_CLOCK) begin
                  if (password_ok) begin
                     if (item.word_index == CLK_CTL_WORD) begin
                        clk_ctl_in = item.write_value[CLK_CTL_BITS-1:0];
                     end else if (item.word_index == CLK_DIV_WORD) begin
                        clk_div_in = item.write_value[DIV_SHIFT +: DIVISOR_BITS];
                     end
                  end
               end else begin
                  if (item.word_index == PWM_CTL_WORD) begin
                     pwm_ctl_in = item.write_value[PWM_CTL_BITS-1:0];
                  end else if (item.word_index == PWM_RNG_WORD) begin
                     range_in = item.write_value;
                  end else if (item.word_index == PWM_DAT_WORD) begin
                     duty_in = item.write_value;
                  end
               end
            end
            FUNC_READ: begin
               if (item.block_sel == BLK_CLOCK) begin
                  if (item.word_index == CLK_CTL_WORD) begin
                     rd_value = DATA_BITS'(clk_ctl_ff);
                  end else if (item.word_index == CLK_DIV_WORD) begin
                     rd_value = DATA_BITS'(clk_div_ff) << DIV_SHIFT;
                  end
               end else begin
                  if (item.word_index == PWM_CTL_WORD) begin
                     rd_value = DATA_BITS'(pwm_ctl_ff);
                  end else if (item.word_index == PWM_RNG_WORD) begin
                     rd_value = range_ff;
                  end else if (item.word_index == PWM_DAT_WORD) begin
                     rd_value = duty_ff;
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clk_ctl_ff <= '0;
         clk_div_ff <= '0;
         pre_ff     <= '0;
         pwm_ctl_ff <= '0;
         range_ff   <= '0;
         duty_ff    <= '0;
         count_ff   <= '0;
      end else begin
         clk_ctl_ff <= clk_ctl_in;
         clk_div_ff <= clk_div_in;
         pre_ff     <= pre_in;
         pwm_ctl_ff <= pwm_ctl_in;
         range_ff   <= range_in;
         duty_ff    <= duty_in;
         count_ff   <= count_in;
      end
   end

   // level as seen after this beat's update
   assign result.read_value = rd_value;
   assign result.pwm_level  = pwm_ctl_in[PWM_EN_BIT] && pwm_ctl_in[PWM_MS_BIT]
                              && (range_in != '0) && (count_in < duty_in);

endmodule

### rtl/pwmcd_out_stage.sv
// Output register: holds one response beat until the receiver takes it.
module pwmcd_out_stage (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              load,
   input  pwmcd_pkg::result_type             result,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [pwmcd_pkg::DATA_BITS-1:0]   rsp_read_value,
   output logic                              rsp_pwm_level
);
   import pwmcd_pkg::*;

   logic       valid_ff;
   logic       valid_in;
   result_type data_ff;

   assign valid_in = load ? 1'b1 : (rsp_ready ? 1'b0 : valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= result;
      end
   end

   assign rsp_valid      = valid_ff;
   assign rsp_read_value = data_ff.read_value;
   assign rsp_pwm_level  = data_ff.pwm_level;

endmodule

### rtl/pwm_channel_with_clock_divider.sv
// Top level: mark-space pwm channel with its clock manager and integer prescaler.
//
// Request channel (req_*): one beat per item, func selects a source-clock tick,
// a register write, a register read or no operation; block_sel and word_index
// address the clock manager (control 40, divisor 41) or the pwm block
// (control 0, range 4, data 5). Clock-manager writes need 0x5A in bits 31:24.
// Response channel (rsp_*): exactly one beat per request, in order, carrying
// the read data (zero for non-reads and unknown offsets) and the pin level
// after the item has taken effect.
// The response passes the input register, then the output register; rsp_valid
// rises when the output register is loaded.
// Throughput: one item per cycle while the receiver takes each response; the
// core updates all state as an item moves from input to output register.
// Reset clears every register but the payload ones: clock stopped, divisor zero,
// channel disabled, range, data and counter zero, both pipeline registers empty.
// When the receiver stalls, the response holds in the output register, the
// input register still takes one further beat, and req_ready then drops until
// the response is taken.
module pwm_channel_with_clock_divider (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [1:0]                        req_func,
   input  logic                              req_block_sel,
   input  logic [pwmcd_pkg::INDEX_BITS-1:0]  req_word_index,
   input  logic [pwmcd_pkg::DATA_BITS-1:0]   req_write_value,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [pwmcd_pkg::DATA_BITS-1:0]   rsp_read_value,
   output logic                              rsp_pwm_level
);
   import pwmcd_pkg::*;

   logic       item_valid;
   item_type   item;
   result_type result;
   logic       advance;

   assign advance = item_valid && (!rsp_valid || rsp_ready);

   pwmcd_in_stage u_in_stage (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_func        (req_func),
      .req_block_sel   (req_block_sel),
      .req_word_index  (req_word_index),
      .req_write_value (req_write_value),
      .advance         (advance),
      .item_valid      (item_valid),
      .item            (item)
   );

   pwmcd_core u_core (
      .clock  (clock),
      .reset  (reset),
      .fire   (advance),
      .item   (item),
      .result (result)
   );

   pwmcd_out_stage u_out_stage (
      .clock          (clock),
      .reset          (reset),
      .load           (advance),
      .result         (result),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_read_value (rsp_read_value),
      .rsp_pwm_level  (rsp_pwm_level)
   );

endmodule

### rtl/pwmcd_checker.sv
// Port checker for the pwm channel, bound to the top level.
`include "pwm_channel_with_clock_divider_assert.svh"

module pwmcd_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_read_value,
   input logic        rsp_pwm_level
);

   `PWMCD_ASSERT_RST(a_reset_empty, reset, !rsp_valid && req_ready, "pipeline not empty after reset")

   `PWMCD_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_read_value) && $stable(rsp_pwm_level), "stalled response beat changed")

   `PWMCD_ASSERT_IMP(a_ready_when_drained, !rsp_valid, req_ready, "request refused with output empty")

   `PWMCD_ASSERT_NEXT(a_rsp_follows, req_valid && req_ready && !rsp_valid, ##1 rsp_valid, "accepted beat gave no response")

endmodule

bind pwm_channel_with_clock_divider pwmcd_checker u_pwmcd_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_ready      (req_ready),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_read_value (rsp_read_value),
   .rsp_pwm_level  (rsp_pwm_level)
);

### tb/tb_pwm_channel_with_clock_divider.sv
// Testbench for the pwm channel with clock divider: directed table, then random traffic.
`timescale 1ns / 100ps

module tb_pwm_channel_with_clock_divider;
   import pwmcd_pkg::*;

   localparam int  DIR_ROWS    = 29;
   localparam int  RAND_ITEMS  = 1750;
   localparam int  CALM_ITEMS  = 250;
   localparam int  CYCLE_LIMIT = 300000;
   localparam int  DRAIN_WAIT  = 8;
   localparam logic BLK_PWM    = ~BLK_CLOCK;
   localparam logic [INDEX_BITS-1:0] UNUSED_WORD = 6'd63;

   typedef struct {
      item_type   it;
      bit         typed;
      result_type want;
   } dir_row_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [1:0]            req_func = FUNC_NONE;
   logic                  req_block_sel = 1'b0;
   logic [INDEX_BITS-1:0] req_word_index = '0;
   logic [DATA_BITS-1:0]  req_write_value = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [DATA_BITS-1:0]  rsp_read_value;
   logic                  rsp_pwm_level;

   bit  idle_on = 1'b1;
   int  fail_count = 0;
   int  cycle_count = 0;

   result_type pin_and_readback_q [$];

   // shadow of the block's registers
   logic [CLK_CTL_BITS-1:0] clk_ctl_q;
   logic [DIVISOR_BITS-1:0] clk_div_q;
   logic [DIVISOR_BITS-1:0] prescale_q;
   logic [PWM_CTL_BITS-1:0] pwm_ctl_q;
   logic [DATA_BITS-1:0]    range_q;
   logic [DATA_BITS-1:0]    duty_q;
   logic [DATA_BITS-1:0]    count_q;

   dir_row_type dir_tab [DIR_ROWS] = '{
      '{'{FUNC_READ,  BLK_CLOCK, CLK_CTL_WORD, 32'h0},        1'b1, '{32'h0, 1'b0}},
      '{'{FUNC_READ,  BLK_CLOCK, CLK_DIV_WORD, 32'h0},        1'b1, '{32'h0, 1'b0}},
      '{'{FUNC_READ,  BLK_PWM,   PWM_RNG_WORD, 32'h0},        1'b1, '{32'h0, 1'b0}},
      '{'{FUNC_READ,  BLK_PWM,   UNUSED_WORD,  32'h0},        1'b1, '{32'h0, 1'b0}},
      '{'{FUNC_NONE,  BLK_PWM,   PWM_DAT_WORD, 32'hFFFFFFFF}, 1'b1, '{32'h0, 1'b0}},
      '{'{FUNC_TICK,  BLK_CLOCK, CLK_CTL_WORD, 32'h0},        1'b1, '{32'h0, 1'b0}},
      '{'{FUNC_WRITE, BLK_CLOCK, CLK_CTL_WORD, 32'h00000011}, 1'b1, '{32'h0, 1'b0}},
      '{'{FUNC_READ,  BLK_CLOCK, CLK_CTL_WORD, 32'h0},        1'b1, '{32'h0, 1'b0}},
      '{'{FUNC_WRITE, BLK_CLOCK, CLK_DIV_WORD, 32'h5A000000}, 1'b1, '{32'h0, 1'b0}},
      '{'{FUNC_WRITE, BLK_CLOCK, CLK_CTL_WORD, 32'h5A000011}, 1'b1, '{32'h0, 1'b0}},
      '{'{FUNC_READ,  BLK_CLOCK, CLK_CTL_WORD, 32'h0},        1'b1, '{32'h11, 1'b0}},
      '{'{FUNC_WRITE, BLK_PWM,   PWM_RNG_WORD, 32'd3},        1'b1, '{32'h0, 1'b0}},
      '{'{FUNC_WRITE, BLK_PWM,   PWM_DAT_WORD, 32'd2},        1'b1, '{32'h0, 1'b0}},
      '{'{FUNC_WRITE, BLK_PWM,   PWM_CTL_WORD, 32'h81},       1'b0, '{32'h0, 1'b0}},
      '{'{FUNC_TICK,  BLK_PWM,   UNUSED_WORD,  32'hFFFFFFFF}, 1'b0, '{32'h0, 1'b0}},
      '{'{FUNC_TICK,  BLK_CLOCK, PWM_CTL_WORD, 32'h0},        1'b0, '{32'h0, 1'b0}},
      '{'{FUNC_TICK,  BLK_CLOCK, PWM_CTL_WORD, 32'h0},        1'b0, '{32'h0, 1'b0}},
      '{'{FUNC_TICK,  BLK_CLOCK, PWM_CTL_WORD, 32'h0},        1'b0, '{32'h0, 1'b0}},
      '{'{FUNC_TICK,  BLK_CLOCK, PWM_CTL_WORD, 32'h0},        1'b0, '{32'h0, 1'b0}},
      '{'{FUNC_WRITE, BLK_PWM,   PWM_RNG_WORD, 32'd1},        1'b0, '{32'h0, 1'b0}},
      '{'{FUNC_TICK,  BLK_CLOCK, PWM_CTL_WORD, 32'h0},        1'b0, '{32'h0, 1'b0}},
      '{'{FUNC_WRITE, BLK_PWM,   PWM_RNG_WORD, 32'd0},        1'b0, '{32'h0, 1'b0}},
      '{'{FUNC_TICK,  BLK_CLOCK, PWM_CTL_WORD, 32'h0},        1'b0, '{32'h0, 1'b0}},
      '{'{FUNC_WRITE, BLK_PWM,   PWM_CTL_WORD, 32'h01},       1'b0, '{32'h0, 1'b0}},
      '{'{FUNC_WRITE, BLK_CLOCK, CLK_CTL_WORD, 32'h5A000031}, 1'b0, '{32'h0, 1'b0}},
      '{'{FUNC_WRITE, BLK_CLOCK, CLK_DIV_WORD, 32'h5AFFFFFF}, 1'b0, '{32'h0, 1'b0}},
      '{'{FUNC_READ,  BLK_CLOCK, CLK_DIV_WORD, 32'h0},        1'b1, '{32'h00FFF000, 1'b0}},
      '{'{FUNC_WRITE, BLK_PWM,   PWM_DAT_WORD, 32'hFFFFFFFF}, 1'b0, '{32'h0, 1'b0}},
      '{'{FUNC_WRITE, BLK_PWM,   UNUSED_WORD,  32'hFFFFFFFF}, 1'b0, '{32'h0, 1'b0}}
   };

   pwm_channel_with_clock_divider dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_func        (req_func),
      .req_block_sel   (req_block_sel),
      .req_word_index  (req_word_index),
      .req_write_value (req_write_value),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_read_value  (rsp_read_value),
      .rsp_pwm_level   (rsp_pwm_level)
   );

   always #4 clock = ~clock;

   function automatic result_type pwm_apply_item(item_type it);
      result_type              r;
      logic [DIVISOR_BITS-1:0] div;
      r.read_value = '0;
      case (it.func)
         FUNC_TICK: begin
            if (clk_ctl_q[CLK_EN_BIT] && !clk_ctl_q[CLK_KILL_BIT]) begin
               div = (clk_div_q == '0) ? DIVISOR_BITS'(1) : clk_div_q;
               if (int'(prescale_q) + 1 >= int'(div)) begin
                  prescale_q = '0;
                  if (!pwm_ctl_q[PWM_EN_BIT] || range_q == '0)
                     count_q = '0;
                  else if (count_q >= range_q - 1)
                     count_q = '0;
                  else
                     count_q = count_q + 1;
               end else begin
                  prescale_q = prescale_q + DIVISOR_BITS'(1);
               end
            end
         end
         FUNC_WRITE: begin
            if (it.block_sel == BLK_CLOCK) begin
               if (it.write_value[31:24] == CLK_PASSWORD) begin
                  if (it.word_index == CLK_CTL_WORD)
                     clk_ctl_q = it.write_value[CLK_CTL_BITS-1:0];
                  else if (it.word_index == CLK_DIV_WORD)
                     clk_div_q = it.write_value[DIV_SHIFT +: DIVISOR_BITS];
               end
            end else begin
               if (it.word_index == PWM_CTL_WORD)
                  pwm_ctl_q = it.write_value[PWM_CTL_BITS-1:0];
               else if (it.word_index == PWM_RNG_WORD)
                  range_q = it.write_value;
               else if (it.word_index == PWM_DAT_WORD)
                  duty_q = it.write_value;
            end
         end
         FUNC_READ: begin
            if (it.block_sel == BLK_CLOCK) begin
               if (it.word_index == CLK_CTL_WORD)
                  r.read_value = DATA_BITS'(clk_ctl_q);
               else if (it.word_index == CLK_DIV_WORD)
                  r.read_value = DATA_BITS'(clk_div_q) << DIV_SHIFT;
            end else begin
               if (it.word_index == PWM_CTL_WORD)
                  r.read_value = DATA_BITS'(pwm_ctl_q);
               else if (it.word_index == PWM_RNG_WORD)
                  r.read_value = range_q;
               else if (it.word_index == PWM_DAT_WORD)
                  r.read_value = duty_q;
            end
         end
         default: ;
      endcase
      r.pwm_level = pwm_ctl_q[PWM_EN_BIT] && pwm_ctl_q[PWM_MS_BIT] && range_q != '0
                    && count_q < duty_q;
      return r;
   endfunction

   task automatic send_item(item_type it, bit typed, result_type want);
      result_type r;
      if (idle_on && $urandom_range(9) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_func        <= it.func;
      req_block_sel   <= it.block_sel;
      req_word_index  <= it.word_index;
      req_write_value <= it.write_value;
      do @(posedge clock); while (!req_ready);
      r = pwm_apply_item(it);
      pin_and_readback_q.push_back(typed ? want : r);
   endtask

   initial begin
      clk_ctl_q  = '0;
      clk_div_q  = '0;
      prescale_q = '0;
      pwm_ctl_q  = '0;
      range_q    = '0;
      duty_q     = '0;
      count_q    = '0;
   end

   // receiver side
   initial begin
      @(posedge clock);
      forever begin
         if (idle_on && $urandom_range(7) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
      end
   end

   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pin_and_readback_q.size() == 0) begin
            $error("response beat with nothing outstanding");
            fail_count++;
         end else begin
            want = pin_and_readback_q.pop_front();
            if (rsp_read_value !== want.read_value) begin
               $error("rsp_read_value: expected %h, got %h", want.read_value, rsp_read_value);
               fail_count++;
            end
            if (rsp_pwm_level !== want.pwm_level) begin
               $error("rsp_pwm_level: expected %b, got %b", want.pwm_level, rsp_pwm_level);
               fail_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("[pwm_channel_with_clock_divider] ERROR");
         $finish;
      end
   end

   initial begin
      item_type   it;
      result_type none;
      logic [31:0] v;
      int         pick;
      none = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < DIR_ROWS; i++)
         send_item(dir_tab[i].it, dir_tab[i].typed, dir_tab[i].want);

      // hold off until the pipeline has drained
      req_valid <= 1'b0;
      while (pin_and_readback_q.size() != 0) @(posedge clock);

      for (int n = 0; n < RAND_ITEMS; n++) begin
         if (n == RAND_ITEMS - CALM_ITEMS)
            idle_on = 1'b0;
         pick           = $urandom_range(99);
         it.func        = FUNC_TICK;
         it.block_sel   = 1'($urandom_range(1));
         it.word_index  = INDEX_BITS'($urandom_range(63));
         it.write_value = $urandom;
         if (pick < 55) begin
            it.func = FUNC_TICK;
         end else if (pick < 70) begin
            it.func      = FUNC_WRITE;
            it.block_sel = BLK_PWM;
            case ($urandom_range(2))
               0: begin
                  it.word_index  = PWM_CTL_WORD;
                  it.write_value = ($urandom_range(3) != 0) ? 32'h81 : $urandom;
               end
               1: begin
                  it.word_index  = PWM_RNG_WORD;
                  it.write_value = ($urandom_range(9) != 0) ? $urandom_range(24) : $urandom;
               end
               default: begin
                  it.word_index  = PWM_DAT_WORD;
                  it.write_value = ($urandom_range(9) != 0) ? $urandom_range(26) : $urandom;
               end
            endcase
         end else if (pick < 78) begin
            it.func      = FUNC_WRITE;
            it.block_sel = BLK_CLOCK;
            v            = $urandom;
            if ($urandom_range(9) != 0)
               v[31:24] = CLK_PASSWORD;
            if ($urandom_range(1) == 0) begin
               it.word_index   = CLK_CTL_WORD;
               v[CLK_EN_BIT]   = ($urandom_range(9) != 0);
               v[CLK_KILL_BIT] = ($urandom_range(9) == 0);
            end else begin
               it.word_index = CLK_DIV_WORD;
               if ($urandom_range(19) != 0)
                  v[DIV_SHIFT +: DIVISOR_BITS] = DIVISOR_BITS'($urandom_range(6));
            end
            it.write_value = v;
         end else if (pick < 88) begin
            it.func = FUNC_READ;
            case ($urandom_range(5))
               0:       it.word_index = CLK_CTL_WORD;
               1:       it.word_index = CLK_DIV_WORD;
               2:       it.word_index = PWM_CTL_WORD;
               3:       it.word_index = PWM_RNG_WORD;
               4:       it.word_index = PWM_DAT_WORD;
               default: it.word_index = INDEX_BITS'($urandom_range(63));
            endcase
         end else begin
            it.func = func_type'($urandom_range(3));
         end
         send_item(it, 1'b0, none);
      end
      req_valid <= 1'b0;

      while (pin_and_readback_q.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (fail_count == 0)
         $display("[pwm_channel_with_clock_divider] OK");
      else
         $display("[pwm_channel_with_clock_divider] ERROR");
      $finish;
   end

endmodule
